// ===== src/twrtc_pkg.sv =====
`default_nettype none

package twrtc_pkg;

    // Data bytes moved by one burst transfer
    localparam int unsigned BURST_BYTES = 8;
    localparam logic [2:0]  LAST_BYTE   = 3'(BURST_BYTES - 1);

    // Configuration register indexes
    localparam logic CFG_BURST_WR_CMD = 1'b0;
    localparam logic CFG_BURST_RD_CMD = 1'b1;

    // Register reset values
    localparam logic [7:0] BURST_WR_CMD_RST = 8'd190;
    localparam logic [7:0] BURST_RD_CMD_RST = 8'd191;

    // Request kinds
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_WRITE    = 3'd1;
    localparam logic [2:0] REQ_READ     = 3'd2;
    localparam logic [2:0] REQ_BURST_WR = 3'd3;
    localparam logic [2:0] REQ_BURST_RD = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  bit_count;
        logic [2:0]  byte_count;
        logic [7:0]  shift_reg;
        logic [7:0]  pending_data;
        logic        is_read;
        logic        is_burst;
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  command_byte;
        logic [7:0]  write_byte;
        logic        pin_in;
    } t_req;

    typedef struct packed {
        logic        chip_enable;
        logic        clock_pulse;
        logic        pin_out;
        logic        pin_drive;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        byte_taken;
        logic [2:0]  byte_number;
        logic        last;
        logic        rejected;
    } t_result;

endpackage

`default_nettype wire

// ===== src/twrtc_step.sv =====
`default_nettype none

module twrtc_step
    import twrtc_pkg::*;
(
    input  wire t_state  i_state,
    input  wire t_req    i_req,
    input  wire [7:0]    i_burst_wr_cmd,
    input  wire [7:0]    i_burst_rd_cmd,
    output t_state       o_state,
    output t_result      o_result
);

    logic       is_req;
    logic       final_byte;
    t_state     s;
    t_result    r;
    logic [7:0] sh;

    always_comb begin
        is_req = i_req.req_type inside {[REQ_WRITE:REQ_BURST_RD]};
        s  = i_state;
        r  = '0;
        sh = '0;
        final_byte = 1'b0;
        r.pin_drive = 1'b1;

        // Start a transaction from idle, or flag a request while busy
        if (s.phase != PH_CMD && s.phase != PH_DATA) begin
            s.phase = PH_IDLE;
            if (is_req) begin
                s.is_read  = (i_req.req_type == REQ_READ) ||
                             (i_req.req_type == REQ_BURST_RD);
                s.is_burst = (i_req.req_type == REQ_BURST_WR) ||
                             (i_req.req_type == REQ_BURST_RD);
                case (i_req.req_type)
                    REQ_WRITE:    s.shift_reg = i_req.command_byte & 8'hFE;
                    REQ_READ:     s.shift_reg = i_req.command_byte | 8'h01;
                    REQ_BURST_WR: s.shift_reg = i_burst_wr_cmd;
                    default:      s.shift_reg = i_burst_rd_cmd;
                endcase
                if (i_req.req_type == REQ_WRITE) begin
                    s.pending_data = i_req.write_byte;
                end
                s.bit_count  = '0;
                s.byte_count = '0;
                s.phase      = PH_CMD;
            end
        end else if (is_req) begin
            r.rejected = 1'b1;
        end

        case (s.phase)
            // Shift out command bits, LSB first
            PH_CMD: begin
                r.chip_enable = 1'b1;
                r.clock_pulse = 1'b1;
                r.pin_out     = s.shift_reg[0];
                s.shift_reg   = {1'b0, s.shift_reg[7:1]};
                if (s.bit_count == 3'd7) begin
                    s.phase      = PH_DATA;
                    s.bit_count  = '0;
                    s.byte_count = '0;
                    s.shift_reg  = (s.is_read || s.is_burst) ? 8'h00 : s.pending_data;
                end else begin
                    s.bit_count = s.bit_count + 3'd1;
                end
            end
            // Move data bits in or out
            PH_DATA: begin
                r.chip_enable = 1'b1;
                r.clock_pulse = 1'b1;
                r.byte_number = s.byte_count;
                if (s.is_read) begin
                    r.pin_drive = 1'b0;
                    s.shift_reg = {i_req.pin_in, s.shift_reg[7:1]};
                    if (s.bit_count == 3'd7) begin
                        r.read_byte  = s.shift_reg;
                        r.read_valid = 1'b1;
                    end
                end else begin
                    sh = s.shift_reg;
                    if (s.bit_count == 3'd0 && s.is_burst) begin
                        sh           = i_req.write_byte;
                        r.byte_taken = 1'b1;
                    end
                    r.pin_out   = sh[0];
                    s.shift_reg = {1'b0, sh[7:1]};
                end
                if (s.bit_count == 3'd7) begin
                    final_byte  = !s.is_burst || (s.byte_count >= LAST_BYTE);
                    s.bit_count = '0;
                    if (final_byte) begin
                        r.last       = 1'b1;
                        s.phase      = PH_IDLE;
                        s.byte_count = '0;
                    end else begin
                        s.byte_count = s.byte_count + 3'd1;
                        s.shift_reg  = '0;
                    end
                end else begin
                    s.bit_count = s.bit_count + 3'd1;
                end
            end
            default: ;
        endcase

        o_state  = s;
        o_result = r;
    end

endmodule

`default_nettype wire

// ===== src/three_wire_rtc_serial_master.sv =====
`default_nettype none

// Three-wire serial master (chip enable, serial clock, data). Each request on
// the slave stream is one bit period; it yields exactly one result on the
// master stream telling how to drive the link in that period. A single write
// or read takes 16 bit periods, a burst 8 + 8 * BURST_BYTES; the request that
// starts a transaction already carries the first command bit, and write, read and
// burst requests made while a transaction runs are flagged as rejected and dropped.
// The block takes one request per clock unless the result stream stalls: the
// per-period update is one pass of logic between the state and output registers,
// and the output register lets a new request in while the last result is taken.
module three_wire_rtc_serial_master
    import twrtc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write port
    input  wire         i_cfg_we,
    input  wire         i_cfg_addr,
    input  wire  [7:0]  i_cfg_wdata,
    // Request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // command_byte[7:0], write_byte[15:8], pin_in[16]
    input  wire  [2:0]  s_axis_tuser,  // req_type[2:0]
    // Result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,  // chip_enable[0], clock_pulse[1], pin_out[2],
                                       // pin_drive[3], read_byte[11:4], read_valid[12],
                                       // byte_taken[13], byte_number[16:14], rejected[17]
    output logic        m_axis_tlast   // last
);

    t_state     r_state, n_state;
    logic [7:0] r_burst_wr_cmd;
    logic [7:0] r_burst_rd_cmd;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    t_req       req;
    logic       accept;

    assign req.req_type     = s_axis_tuser;
    assign req.command_byte = s_axis_tdata[7:0];
    assign req.write_byte   = s_axis_tdata[15:8];
    assign req.pin_in       = s_axis_tdata[16];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    twrtc_step u_step (
        .i_state        (r_state),
        .i_req          (req),
        .i_burst_wr_cmd (r_burst_wr_cmd),
        .i_burst_rd_cmd (r_burst_rd_cmd),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_wr_cmd <= BURST_WR_CMD_RST;
            r_burst_rd_cmd <= BURST_RD_CMD_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_BURST_WR_CMD) begin
                r_burst_wr_cmd <= i_cfg_wdata;
            end else begin
                r_burst_rd_cmd <= i_cfg_wdata;
            end
        end
    end

    // Advance link state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {6'd0,
                            r_out.rejected,
                            r_out.byte_number,
                            r_out.byte_taken,
                            r_out.read_valid,
                            r_out.read_byte,
                            r_out.pin_drive,
                            r_out.pin_out,
                            r_out.clock_pulse,
                            r_out.chip_enable};

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import twrtc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;  // command_byte[7:0], write_byte[15:8], pin_in[16]
    logic [2:0]  s_axis_tuser;  // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;  // chip_enable[0], clock_pulse[1], pin_out[2], pin_drive[3],
                                // read_byte[11:4], read_valid[12], byte_taken[13],
                                // byte_number[16:14], rejected[17]
    logic        m_axis_tlast;  // last

    three_wire_rtc_serial_master DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Tracks the serial link state and holds the bit periods still owed by the block
    class serial_link_checker;
        logic [7:0]  burst_wr_cmd;
        logic [7:0]  burst_rd_cmd;
        t_phase      link_phase;
        logic [2:0]  bit_cnt;
        logic [2:0]  byte_cnt;
        logic [7:0]  shifter;
        logic [7:0]  write_hold;
        logic        reading;
        logic        bursting;
        t_result     pending_periods[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned periods;
        int unsigned starts[5];
        int unsigned rejects;
        int unsigned bytes_read;

        function new();
            burst_wr_cmd = BURST_WR_CMD_RST;
            burst_rd_cmd = BURST_RD_CMD_RST;
            link_phase   = PH_IDLE;
            bit_cnt      = '0;
            byte_cnt     = '0;
            shifter      = '0;
            write_hold   = '0;
            reading      = 1'b0;
            bursting     = 1'b0;
            failures     = 0;
            checked      = 0;
            periods      = 0;
            rejects      = 0;
            bytes_read   = 0;
            foreach (starts[k]) starts[k] = 0;
        endfunction

        function void set_register(logic idx, logic [7:0] value);
            if (idx == CFG_BURST_WR_CMD) burst_wr_cmd = value;
            else burst_rd_cmd = value;
        endfunction

        function bit busy();
            return link_phase == PH_CMD || link_phase == PH_DATA;
        endfunction

        // Advance the link by one bit period and queue what the block must report
        function void note_request(t_req r);
            t_result    e;
            logic [7:0] cmd;
            bit         is_req;
            bit         final_byte;
            e = '0;
            e.pin_drive = 1'b1;
            is_req = r.req_type >= REQ_WRITE && r.req_type <= REQ_BURST_RD;
            periods++;

            // Start a transaction from idle, or flag a request that collides with one
            if (!busy()) begin
                link_phase = PH_IDLE;
                if (is_req) begin
                    reading  = r.req_type == REQ_READ || r.req_type == REQ_BURST_RD;
                    bursting = r.req_type >= REQ_BURST_WR;
                    case (r.req_type)
                        REQ_WRITE:    cmd = r.command_byte & 8'hFE;
                        REQ_READ:     cmd = r.command_byte | 8'h01;
                        REQ_BURST_WR: cmd = burst_wr_cmd;
                        default:      cmd = burst_rd_cmd;
                    endcase
                    if (r.req_type == REQ_WRITE) write_hold = r.write_byte;
                    shifter    = cmd;
                    bit_cnt    = '0;
                    byte_cnt   = '0;
                    link_phase = PH_CMD;
                    starts[r.req_type]++;
                end
            end else if (is_req) begin
                e.rejected = 1'b1;
                rejects++;
            end

            if (link_phase == PH_CMD) begin
                // Shift out the command byte, LSB first
                e.chip_enable = 1'b1;
                e.clock_pulse = 1'b1;
                e.pin_out     = shifter[0];
                shifter       = shifter >> 1;
                if (bit_cnt == 3'd7) begin
                    link_phase = PH_DATA;
                    bit_cnt    = '0;
                    byte_cnt   = '0;
                    shifter    = (reading || bursting) ? 8'h00 : write_hold;
                end else begin
                    bit_cnt++;
                end
            end else if (link_phase == PH_DATA) begin
                e.chip_enable = 1'b1;
                e.clock_pulse = 1'b1;
                e.byte_number = byte_cnt;
                if (reading) begin
                    // Release the pin and shift the sampled bit in at the top
                    e.pin_drive = 1'b0;
                    shifter = {r.pin_in, shifter[7:1]};
                    if (bit_cnt == 3'd7) begin
                        e.read_byte  = shifter;
                        e.read_valid = 1'b1;
                        bytes_read++;
                    end
                end else begin
                    // Burst writes take a fresh byte at each byte start
                    if (bit_cnt == 3'd0 && bursting) begin
                        shifter      = r.write_byte;
                        e.byte_taken = 1'b1;
                    end
                    e.pin_out = shifter[0];
                    shifter   = shifter >> 1;
                end
                if (bit_cnt == 3'd7) begin
                    final_byte = !bursting || byte_cnt == LAST_BYTE;
                    bit_cnt    = '0;
                    if (final_byte) begin
                        e.last     = 1'b1;
                        link_phase = PH_IDLE;
                        byte_cnt   = '0;
                    end else begin
                        byte_cnt++;
                        shifter = 8'h00;
                    end
                end else begin
                    bit_cnt++;
                end
            end
            pending_periods.push_back(e);
        endfunction

        function int field_diff(string field_name, logic [7:0] want, logic [7:0] seen);
            if (seen === want) return 0;
            if (failures < 10)
                $display("period %0d: %s expected %0h got %0h",
                         checked, field_name, want, seen);
            return 1;
        endfunction

        // Compare one delivered period against the oldest one owed
        function void check_period(t_result got);
            t_result e;
            int      bad;
            if (pending_periods.size() == 0) begin
                if (failures < 10) $display("unexpected result %h with nothing owed", got);
                failures++;
                return;
            end
            e = pending_periods.pop_front();
            bad = 0;
            bad += field_diff("chip_enable", e.chip_enable, got.chip_enable);
            bad += field_diff("clock_pulse", e.clock_pulse, got.clock_pulse);
            bad += field_diff("pin_out",     e.pin_out,     got.pin_out);
            bad += field_diff("pin_drive",   e.pin_drive,   got.pin_drive);
            bad += field_diff("read_byte",   e.read_byte,   got.read_byte);
            bad += field_diff("read_valid",  e.read_valid,  got.read_valid);
            bad += field_diff("byte_taken",  e.byte_taken,  got.byte_taken);
            bad += field_diff("byte_number", e.byte_number, got.byte_number);
            bad += field_diff("last",        e.last,        got.last);
            bad += field_diff("rejected",    e.rejected,    got.rejected);
            if (bad != 0) failures++;
            checked++;
        endfunction
    endclass

    serial_link_checker link = new();
    bit      quiet_tail;
    t_result seen_period;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run ends here if the block hangs
    initial begin
        #400000;
        $display("FAIL three_wire_rtc_serial_master");
        $finish;
    end

    // Sample delivered periods at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_period.chip_enable = m_axis_tdata[0];
            seen_period.clock_pulse = m_axis_tdata[1];
            seen_period.pin_out     = m_axis_tdata[2];
            seen_period.pin_drive   = m_axis_tdata[3];
            seen_period.read_byte   = m_axis_tdata[11:4];
            seen_period.read_valid  = m_axis_tdata[12];
            seen_period.byte_taken  = m_axis_tdata[13];
            seen_period.byte_number = m_axis_tdata[16:14];
            seen_period.rejected    = m_axis_tdata[17];
            seen_period.last        = m_axis_tlast;
            link.check_period(seen_period);
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        int unsigned hold;
        bit          long_hold_done;
        hold = 0;
        long_hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && link.checked >= 150) begin
                hold = 64;
                long_hold_done = 1'b1;
            end else if (hold == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 8);
            end
            if (hold != 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one bit period and wait until the block takes it
    task automatic send_period(input t_req r);
        int unsigned gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
        if (gap != 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req_type;
        s_axis_tdata  <= {7'b0, r.pin_in, r.write_byte, r.command_byte};
        do @(posedge i_clk); while (!s_axis_tready);
        link.note_request(r);
    endtask

    task automatic send_fields(input logic [2:0] kind, input logic [7:0] cmd,
                               input logic [7:0] wdata, input logic pin);
        t_req r;
        r.req_type     = kind;
        r.command_byte = cmd;
        r.write_byte   = wdata;
        r.pin_in       = pin;
        send_period(r);
    endtask

    // Hold the sender until every owed period has arrived, then let the pipe settle
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (link.pending_periods.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        link.set_register(idx, value);
    endtask

    // Mostly well-formed transactions: start from idle, then ticks with some noise
    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned pick;
        logic [2:0]  kind;
        sent = 0;
        while (sent < count || link.busy()) begin
            pick = $urandom_range(0, 19);
            if (!link.busy()) begin
                if (pick < 2)       kind = REQ_TICK;
                else if (pick < 3)  kind = 3'($urandom_range(5, 7));
                else if (pick < 9)  kind = REQ_WRITE;
                else if (pick < 15) kind = REQ_READ;
                else if (pick < 17) kind = REQ_BURST_WR;
                else                kind = REQ_BURST_RD;
            end else begin
                if (pick == 0)      kind = 3'($urandom_range(REQ_WRITE, REQ_BURST_RD));
                else if (pick == 1) kind = 3'($urandom_range(5, 7));
                else                kind = REQ_TICK;
            end
            send_fields(kind, 8'($urandom), 8'($urandom), 1'($urandom));
            sent++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = 1'b0;
        i_cfg_wdata   = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 24'h0;
        s_axis_tuser  = REQ_TICK;
        quiet_tail    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle ticks with extreme fields, including an unknown kind
        send_fields(REQ_TICK, 8'hFF, 8'hFF, 1'b1);
        send_fields(3'd7, 8'h00, 8'h00, 1'b0);
        // Single write: command bit0 forced low; collide with requests mid-flight
        send_fields(REQ_WRITE, 8'hFF, 8'h00, 1'b1);
        for (int k = 0; k < 15; k++) begin
            if (k == 3)      send_fields(REQ_BURST_RD, 8'h55, 8'hAA, 1'b1);
            else if (k == 9) send_fields(REQ_WRITE, 8'hFF, 8'hFF, 1'b0);
            else if (k == 5) send_fields(3'd5, 8'h00, 8'hFF, 1'b1);
            else             send_fields(REQ_TICK, 8'h00, 8'h00, 1'(k));
        end
        // Single read: command bit0 forced high; the random part finishes it
        send_fields(REQ_READ, 8'h00, 8'hFF, 1'b0);
        for (int k = 0; k < 7; k++) send_fields(REQ_TICK, 8'hFF, 8'h00, 1'b1);

        run_random(130);
        drain_results();
        write_register(CFG_BURST_WR_CMD, 8'h00);
        write_register(CFG_BURST_RD_CMD, 8'hFF);
        run_random(130);
        drain_results();
        write_register(CFG_BURST_WR_CMD, 8'hFF);
        write_register(CFG_BURST_RD_CMD, 8'h00);
        run_random(130);
        drain_results();
        write_register(CFG_BURST_WR_CMD, 8'($urandom));
        write_register(CFG_BURST_RD_CMD, 8'($urandom));
        quiet_tail = 1'b1;
        run_random(130);
        drain_results();
        repeat (8) @(posedge i_clk);

        if (link.pending_periods.size() != 0) begin
            $display("%0d periods never delivered", link.pending_periods.size());
            link.failures++;
        end
        $display("Ran %0d periods: %0d writes, %0d reads, %0d burst writes, %0d burst reads",
                 link.periods, link.starts[REQ_WRITE], link.starts[REQ_READ],
                 link.starts[REQ_BURST_WR], link.starts[REQ_BURST_RD]);
        $display("%0d busy collisions, %0d bytes read back, %0d failing periods",
                 link.rejects, link.bytes_read, link.failures);
        if (link.failures == 0) begin
            $display("PASS three_wire_rtc_serial_master");
        end else begin
            $display("FAIL three_wire_rtc_serial_master");
        end
        $finish;
    end

endmodule
